FILE: design/asd_pkg.sv
package asd_pkg;

  // moving average window length
  localparam int unsigned Window = 5;

  localparam int unsigned AccW  = 16;
  localparam int unsigned MagW  = 16;
  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 16;

  // sum of three squares of axis magnitudes (at most 2^15) stays below 2^32
  localparam int unsigned RadW  = 32;
  localparam int unsigned RootW = RadW / 2;
  localparam int unsigned RemW  = RootW + 2;
  localparam int unsigned IterW = $clog2(RootW);

  localparam int unsigned PosW = (Window > 1) ? $clog2(Window) : 1;
  localparam int unsigned SumW = MagW + $clog2(Window);

  // floor(sum / Window) as (sum * RecipK) >> DivShift, exact for every sum below 2^SumW
  localparam int unsigned DivShift = SumW + $clog2(Window);
  localparam int unsigned MulW     = SumW + 1;
  localparam int unsigned ProdW    = 2 * MulW;
  localparam logic [MulW-1:0] RecipK =
    MulW'(((64'd1 << DivShift) + 64'(Window) - 64'd1) / 64'(Window));

  localparam int unsigned CfgIdxW = 1;

  typedef enum logic [CfgIdxW-1:0] {
    RegThreshold = 1'b0,
    RegCooldown  = 1'b1
  } cfg_reg_e;

  localparam logic [CfgW-1:0] DefThreshold = 16'd9356;
  localparam logic [CfgW-1:0] DefCooldown  = 16'd300;

endpackage

FILE: design/asd_mul.sv
module asd_mul (
  input  logic                    clk_i,
  input  logic [asd_pkg::MulW-1:0]  a_i,
  input  logic [asd_pkg::MulW-1:0]  b_i,
  output logic [asd_pkg::ProdW-1:0] p_o
);
  import asd_pkg::*;

  logic [ProdW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= ProdW'(a_i) * ProdW'(b_i);
  end

  assign p_o = p_q;

endmodule

FILE: design/asd_isqrt.sv
module asd_isqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [asd_pkg::RadW-1:0]  rad_i,
  output logic                      done_o,
  output logic [asd_pkg::RootW-1:0] root_o
);
  import asd_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [IterW-1:0]  cnt_q, cnt_d;
  logic [RadW-1:0]   rad_q, rad_d;
  logic [RemW-1:0]   rem_q, rem_d;
  logic [RootW-1:0]  root_q, root_d;
  logic [RemW+1:0]   rem_shift;
  logic [RemW+1:0]   trial;

  // one result bit per cycle, two radicand bits brought down each time
  always_comb begin
    rem_shift = {rem_q, rad_q[RadW-1 -: 2]};
    trial     = (RemW + 2)'({root_q, 2'b01});
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    rad_d     = rad_q;
    rem_d     = rem_q;
    root_d    = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rad_d = {rad_q[RadW-3:0], 2'b00};
      if (rem_shift >= trial) begin
        rem_d  = RemW'(rem_shift - trial);
        root_d = {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_d  = RemW'(rem_shift);
        root_d = {root_q[RootW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == IterW'(RootW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

FILE: design/accel_step_detector.sv
// step detector on the acceleration magnitude
// input channel: in_valid_i / in_stall_o carry one sample (three signed axes in raw
// counts and a millisecond timestamp). output channel: out_valid_o / out_stall_i carry
// one result per sample: the windowed average magnitude, a step flag and the step count.
// an item is taken at a clock edge with valid high and stall low.
// after an item is accepted, the shared multiplier squares the axes, the bit-serial
// square root takes the root of their sum, the window is updated and the step is
// decided once the root is done, a reciprocal multiply forms the average, and the
// output register is loaded, raising out_valid_o, unless an earlier result is stalled.
// items are taken one at a time; in_stall_o is high while an item is at work.
// the result sits in an output register, so the next item is taken while it waits;
// if the receiver still stalls when the following result is done, the block holds
// that result and keeps stalling its input.
// config: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 threshold, 1 cooldown).
// the user must write only while no item is in flight; the block does not enforce it.
// reset clears the magnitude window, the window sum, the last step time and the step
// count, and loads threshold 9356 and cooldown 300.
module accel_step_detector (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [asd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [asd_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [asd_pkg::AccW-1:0] accel_x_i,
  input  logic signed [asd_pkg::AccW-1:0] accel_y_i,
  input  logic signed [asd_pkg::AccW-1:0] accel_z_i,
  input  logic [asd_pkg::TimeW-1:0]   time_ms_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [asd_pkg::MagW-1:0]    filtered_magnitude_o,
  output logic                        step_detected_o,
  output logic [asd_pkg::TimeW-1:0]   step_count_o
);
  import asd_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SQR  = 6'b000010,
    S_ROOT = 6'b000100,
    S_UPD  = 6'b001000,
    S_DIV  = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [CfgW-1:0]  thr_q, cool_q;
  logic [AccW-1:0]  ax_q, ay_q, az_q;
  logic [TimeW-1:0] time_q;
  logic [1:0]       cnt_q, cnt_d;
  logic [RadW-1:0]  acc_q, acc_d;

  logic [MagW-1:0]  ring_q [Window];
  logic [PosW-1:0]  pos_q;
  logic [SumW-1:0]  sum_q;
  logic [TimeW-1:0] last_q;
  logic [TimeW-1:0] total_q;
  logic             step_q;

  logic             out_valid_q;
  logic [MagW-1:0]  mag_out_q;
  logic             step_out_q;
  logic [TimeW-1:0] count_out_q;

  logic [MulW-1:0]  mul_a, mul_b;
  logic [ProdW-1:0] prod;
  logic             sqrt_start;
  logic [RadW-1:0]  sqrt_rad;
  logic             sqrt_done;
  logic [RootW-1:0] sqrt_root;

  logic             accept;
  logic             out_load;
  logic [SumW-1:0]  sum_new;
  logic [SumW-1:0]  thr_win;
  logic [TimeW-1:0] elapsed;
  logic             step_now;

  function automatic logic [AccW-1:0] abs_val(input logic [AccW-1:0] v);
    logic [AccW:0] neg;
    neg = -{v[AccW-1], v};
    return v[AccW-1] ? neg[AccW-1:0] : v;
  endfunction

  asd_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  asd_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (sqrt_rad),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  assign sum_new  = sum_q - SumW'(ring_q[pos_q]) + SumW'(sqrt_root);
  assign thr_win  = SumW'(thr_q * Window);
  assign elapsed  = time_q - last_q;
  assign step_now = (sum_new > thr_win) && (elapsed > TimeW'(cool_q));

  // shared multiplier: squares of the axes, then the reciprocal for the average
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == S_SQR) begin
      case (cnt_q)
        2'd0:    mul_a = MulW'(ax_q);
        2'd1:    mul_a = MulW'(ay_q);
        2'd2:    mul_a = MulW'(az_q);
        default: mul_a = '0;
      endcase
      mul_b = mul_a;
    end else if (state_q == S_UPD || state_q == S_DIV || state_q == S_OUT) begin
      mul_a = MulW'(sum_q);
      mul_b = RecipK;
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (state_q == S_SQR && cnt_q != 2'd0) begin
      acc_d = acc_q + prod[RadW-1:0];
    end
  end

  assign sqrt_start = (state_q == S_SQR) && (cnt_q == 2'd3);
  assign sqrt_rad   = acc_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (accept) begin
          state_d = S_SQR;
        end
      end
      S_SQR: begin
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          state_d = S_ROOT;
        end
      end
      S_ROOT: begin
        if (sqrt_done) begin
          state_d = S_UPD;
        end
      end
      S_UPD: state_d = S_DIV;
      S_DIV: state_d = S_OUT;
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      thr_q   <= DefThreshold;
      cool_q  <= DefCooldown;
      for (int i = 0; i < Window; i++) begin
        ring_q[i] <= '0;
      end
      pos_q       <= '0;
      sum_q       <= '0;
      last_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      count_out_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegThreshold: thr_q  <= cfg_data_i;
          RegCooldown:  cool_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == S_ROOT && sqrt_done) begin
        ring_q[pos_q] <= sqrt_root;
        sum_q         <= sum_new;
        pos_q         <= (pos_q == PosW'(Window - 1)) ? '0 : pos_q + 1'b1;
        if (step_now) begin
          total_q <= total_q + 1'b1;
          last_q  <= time_q;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        count_out_q <= total_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ax_q   <= abs_val(accel_x_i);
      ay_q   <= abs_val(accel_y_i);
      az_q   <= abs_val(accel_z_i);
      time_q <= time_ms_i;
      acc_q  <= '0;
    end else begin
      acc_q <= acc_d;
    end
    if (state_q == S_ROOT && sqrt_done) begin
      step_q <= step_now;
    end
    if (out_load) begin
      mag_out_q  <= prod[DivShift +: MagW];
      step_out_q <= step_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign filtered_magnitude_o = mag_out_q;
  assign step_detected_o      = step_out_q;
  assign step_count_o         = count_out_q;

  // a counted step means the window average reached the threshold
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (!step_detected_o || filtered_magnitude_o >= thr_q))
    else $error("step flagged below threshold");

  // the count moves by exactly the step flag of each result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> step_count_o == $past(step_count_o) + TimeW'(step_detected_o))
    else $error("step count out of step with flag");

  // the root finishes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_done |-> state_q == S_ROOT)
    else $error("square root done outside root phase");

endmodule
